[src/trickle_timer_assert.svh]
// Assertion macros used by the trickle timer RTL.
`ifndef TRICKLE_TIMER_ASSERT_SVH
`define TRICKLE_TIMER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trickle_timer: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trickle_timer: next-cycle check failed");

`endif

[src/tt_pkg.sv]
package tt_pkg;

    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DATA_W);
    localparam int HEARD_W = 16;
    localparam int EXP_W   = 5;
    localparam int LIMIT_W = 8;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;
    localparam logic [OP_W-1:0] OP_HEARD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLINGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    localparam logic [EXP_W-1:0]   RST_MIN_EXP   = 5'd3;
    localparam logic [EXP_W-1:0]   RST_DOUBLINGS = 5'd20;
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = 8'd10;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic publish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic draw;
        logic div_last;
    } t_status;

endpackage

[src/tt_ctrl.sv]
module tt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    input  tt_pkg::t_status i_status,
    output tt_pkg::t_cmd    o_cmd,
    output logic            o_stall,
    output logic            o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIVIDE,
        S_PUBLISH
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.publish  = (r_state == S_PUBLISH) && (!r_valid || !i_stall);
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_status.draw ? S_DIVIDE : S_PUBLISH;
            end
            S_DIVIDE: begin
                if (i_status.div_last) n_state = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (o_cmd.publish) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

[src/tt_dpath.sv]
module tt_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tt_pkg::t_cmd                    i_cmd,
    output tt_pkg::t_status                 o_status,
    input  logic                            i_cfg_we,
    input  logic [tt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [tt_pkg::OP_W-1:0]         i_opcode,
    input  logic [tt_pkg::DATA_W-1:0]       i_random_word,
    output logic                            o_send_beacon,
    output logic                            o_interval_started,
    output logic [tt_pkg::DATA_W-1:0]       o_interval_length,
    output logic [tt_pkg::DATA_W-1:0]       o_fire_time
);

    localparam int W = tt_pkg::DATA_W;

    // configuration
    logic [tt_pkg::EXP_W-1:0]   r_min_exp;
    logic [tt_pkg::EXP_W-1:0]   r_doublings;
    logic [tt_pkg::LIMIT_W-1:0] r_limit;

    // timer state
    logic [W-1:0]                r_interval, r_fire, r_elapsed;
    logic [tt_pkg::HEARD_W-1:0]  r_heard;
    logic                        r_running;

    // item and draw registers
    logic [tt_pkg::OP_W-1:0]  r_op;
    logic [W-1:0]             r_rand;
    logic [W-1:0]             r_half, r_divisor, r_rem;
    logic [tt_pkg::CNT_W-1:0] r_cnt;
    logic                     r_send, r_started;

    // output word
    logic         r_out_send, r_out_started;
    logic [W-1:0] r_out_interval, r_out_fire;

    logic [W-1:0] imin, cap, start_len, dbl_len, new_len, elapsed_inc, fire_at, end_at;
    logic         is_tick, interval_end, draw, permit;
    logic [W:0]   shifted;
    logic         ge;
    logic [W-1:0] rem_next;

    always_comb begin
        imin      = W'(1) << r_min_exp;
        cap       = imin << r_doublings;
        // mask wraps to all ones when 4*Imin overflows: remainder is the word itself
        start_len = imin + (r_rand & ((imin << 2) - W'(1)));
        dbl_len   = r_interval << 1;
        if (dbl_len == '0 || dbl_len > cap) dbl_len = cap;

        elapsed_inc  = r_elapsed + W'(1);
        fire_at      = (r_fire == '0) ? W'(1) : r_fire;
        end_at       = (r_interval == '0) ? W'(1) : r_interval;
        is_tick      = (r_op == tt_pkg::OP_TICK) && r_running;
        interval_end = is_tick && (elapsed_inc >= end_at);
        permit       = (tt_pkg::HEARD_W'(r_limit) > r_heard) || (r_limit == '0);

        draw = (r_op == tt_pkg::OP_START) || (r_op == tt_pkg::OP_RESET) || interval_end;

        case (r_op)
            tt_pkg::OP_START: new_len = start_len;
            tt_pkg::OP_RESET: new_len = imin;
            default:          new_len = dbl_len;
        endcase

        // restoring remainder step, one quotient bit per cycle
        shifted  = {r_rem, r_rand[W-1]};
        ge       = shifted >= {1'b0, r_divisor};
        rem_next = ge ? W'(shifted - {1'b0, r_divisor}) : shifted[W-1:0];
    end

    assign o_status.draw     = draw;
    assign o_status.div_last = &r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_exp   <= tt_pkg::RST_MIN_EXP;
            r_doublings <= tt_pkg::RST_DOUBLINGS;
            r_limit     <= tt_pkg::RST_LIMIT;
            r_interval  <= '0;
            r_fire      <= '0;
            r_elapsed   <= '0;
            r_heard     <= '0;
            r_running   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tt_pkg::CFG_MIN_EXP:   r_min_exp   <= i_cfg_data[tt_pkg::EXP_W-1:0];
                    tt_pkg::CFG_DOUBLINGS: r_doublings <= i_cfg_data[tt_pkg::EXP_W-1:0];
                    tt_pkg::CFG_LIMIT:     r_limit     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                if (r_op == tt_pkg::OP_HEARD) r_heard <= r_heard + 1'b1;
                if (draw) begin
                    r_interval <= new_len;
                    r_elapsed  <= '0;
                    r_heard    <= '0;
                    r_running  <= 1'b1;
                end else if (is_tick) begin
                    r_elapsed <= elapsed_inc;
                end
            end
            if (i_cmd.div_step && (&r_cnt)) r_fire <= r_half + rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_rand <= i_random_word;
        end
        if (i_cmd.exec) begin
            r_send    <= is_tick && (elapsed_inc == fire_at) && permit;
            r_started <= draw;
            r_half    <= new_len >> 1;
            r_divisor <= new_len - (new_len >> 1) + W'(1);
            r_rem     <= '0;
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_next;
            r_rand <= r_rand << 1;
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.publish) begin
            r_out_send     <= r_send;
            r_out_started  <= r_started;
            r_out_interval <= r_interval;
            r_out_fire     <= r_fire;
        end
    end

    assign o_send_beacon      = r_out_send;
    assign o_interval_started = r_out_started;
    assign o_interval_length  = r_out_interval;
    assign o_fire_time        = r_out_fire;

endmodule

[src/trickle_timer.sv]
// Trickle timer for routing beacons.
// Input channel (i_valid / o_stall): one word per event, i_opcode selects a
// one-millisecond tick, start, reset or message heard; i_random_word feeds
// every random draw the event makes. A word is taken when i_valid is high
// and o_stall is low.
// Output channel (o_valid / i_stall): exactly one result word per input
// word, in order: send flag, interval-started flag, current interval length
// and fire time. The word is held in an output register until taken.
// An event that draws no new interval goes through execute and then
// publish; one that begins an interval also runs the bit-serial remainder
// unit (32 steps) that draws the fire time before publish. One word in
// flight; the next is accepted as soon as the result sits in the output
// register, even if the receiver stalls it. A stalled receiver holds the
// result and, after one more word, stalls the input side too.
// Config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
// Reset (synchronous, active low): timer idle until start or reset event,
// Imin exponent 3, 20 doublings, redundancy limit 10, output empty.
module trickle_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tt_pkg::OP_W-1:0]         i_opcode,
    input  logic [tt_pkg::DATA_W-1:0]       i_random_word,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_send_beacon,
    output logic                            o_interval_started,
    output logic [tt_pkg::DATA_W-1:0]       o_interval_length,
    output logic [tt_pkg::DATA_W-1:0]       o_fire_time
);

    `include "trickle_timer_assert.svh"

    tt_pkg::t_cmd    cmd;
    tt_pkg::t_status status;

    // sequencer: accept, execute, divide, publish
    tt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    // timer state, config registers, remainder unit and output word
    tt_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_opcode),
        .i_random_word      (i_random_word),
        .o_send_beacon      (o_send_beacon),
        .o_interval_started (o_interval_started),
        .o_interval_length  (o_interval_length),
        .o_fire_time        (o_fire_time)
    );

    // an accepted word makes the block busy in the next cycle
    `TT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // the remainder unit only runs while input is held off
    `TT_ASSERT_SAME(a_stall_while_divide, i_clk, i_rst_n, cmd.div_step, o_stall)
    // a pending result word is never overwritten
    `TT_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.publish, !o_valid || !i_stall)

endmodule
